// ----- rtl/core/wfps_pkg.sv -----
`default_nettype none
package wfps_pkg;

    // default sizes
    localparam int MAX_WINDOW_DEF  = 2048;
    localparam int MAX_BINS_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 16;

    // port field widths
    localparam int OPC_BITS      = 2;
    localparam int SLOT_BITS     = 11;
    localparam int VALUE_BITS    = 16;
    localparam int LEN_BITS      = 12;
    localparam int STEP_BITS     = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int FRAME_BITS    = 24;
    localparam int POWER_BITS    = 54;
    localparam int STATUS_BITS   = 2;

    // opcodes
    localparam logic [OPC_BITS-1:0] OP_LOAD = 2'd0;
    localparam logic [OPC_BITS-1:0] OP_PUSH = 2'd1;
    localparam logic [OPC_BITS-1:0] OP_READ = 2'd2;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOFRAME = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_LEN = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOP_LEN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ANGLE   = 2'd2;

    // register reset values
    localparam logic [LEN_BITS-1:0]  WIN_LEN_RST = 12'd1024;
    localparam logic [LEN_BITS-1:0]  HOP_LEN_RST = 12'd256;
    localparam logic [STEP_BITS-1:0] ANGLE_RST   = 32'd4194304;

    // twiddle table
    localparam int TW_BITS     = 12;
    localparam int TW_SIZE     = 4096;
    localparam int TW_QUARTER  = 1024;
    localparam int TW_VAL_BITS = 16;
    localparam int TW_FRAC     = 15;

    // cordic table builder
    localparam int CORDIC_BITS   = 34;
    localparam int CORDIC_STAGES = 16;
    localparam logic signed [CORDIC_BITS-1:0] CORDIC_X0 = 34'sd652032874;

    // power saturation
    localparam int MAG_BITS  = 28;
    localparam int MAG_LIMIT = 134217728;
    localparam logic [POWER_BITS-1:0] PMASK = {POWER_BITS{1'b1}};

    typedef struct packed {
        logic                          en;
        logic [TW_BITS-1:0]            addr;
        logic signed [TW_VAL_BITS-1:0] data;
    } t_tw_wr;

    // arctangent of 2^-i in units of 2^32 per turn
    function automatic logic signed [CORDIC_BITS-1:0] atan_unit(input logic [3:0] i);
        logic signed [CORDIC_BITS-1:0] a;
        case (i)
            4'd0:    a = 34'sd536870912;
            4'd1:    a = 34'sd316933406;
            4'd2:    a = 34'sd167458907;
            4'd3:    a = 34'sd85004756;
            4'd4:    a = 34'sd42667331;
            4'd5:    a = 34'sd21354465;
            4'd6:    a = 34'sd10679838;
            4'd7:    a = 34'sd5340245;
            4'd8:    a = 34'sd2670163;
            4'd9:    a = 34'sd1335087;
            4'd10:   a = 34'sd667544;
            4'd11:   a = 34'sd333772;
            4'd12:   a = 34'sd166886;
            4'd13:   a = 34'sd83443;
            4'd14:   a = 34'sd41722;
            default: a = 34'sd20861;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/windowed_frame_power_spectrum_unit.sv -----
// Short-time power spectrum. Words on the input channel load window
// coefficients, push samples into a ring of the latest MAX_WINDOW samples, or
// read back one power bin of the latest frame; every word returns exactly one
// result word. After reset the block builds its 4096-entry cosine table with
// an iterative CORDIC and takes no word until the build is done; register
// writes are taken during that time. A load or a push that does not finish a
// frame goes from S_IDLE to S_OUT; a read passes through S_READ on the way. A
// push that finishes a frame of length N runs one windowing pass over the ring,
// then one complex multiply-accumulate per cycle, fed by single reads of the
// frame buffer and the two twiddle memories, for each of the N/2 bins. Results
// wait in an output register, so the next word can be taken while the previous
// result has not yet been taken.
`default_nettype none
module windowed_frame_power_spectrum_unit #(
    parameter int MAX_WINDOW  = wfps_pkg::MAX_WINDOW_DEF,
    parameter int MAX_BINS    = wfps_pkg::MAX_BINS_DEF,
    parameter int SAMPLE_BITS = wfps_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = wfps_pkg::COEF_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [wfps_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [wfps_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [wfps_pkg::OPC_BITS-1:0]        i_opcode,
    input  wire logic [wfps_pkg::SLOT_BITS-1:0]       i_slot,
    input  wire logic signed [wfps_pkg::VALUE_BITS-1:0] i_value,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic                                      o_frame_done,
    output logic [wfps_pkg::FRAME_BITS-1:0]           o_frame_number,
    output logic [wfps_pkg::POWER_BITS-1:0]           o_bin_power,
    output logic [wfps_pkg::POWER_BITS-1:0]           o_least_power,
    output logic [wfps_pkg::POWER_BITS-1:0]           o_greatest_power,
    output logic [wfps_pkg::STATUS_BITS-1:0]          o_status
);
    import wfps_pkg::*;

    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int LW   = $clog2(MAX_WINDOW + 1);
    localparam int BIW  = $clog2(MAX_BINS);
    localparam int BW   = $clog2(MAX_BINS + 1);
    localparam int PW   = SAMPLE_BITS + COEF_BITS;
    localparam int XW   = SAMPLE_BITS + 1;
    localparam int MW   = XW + TW_VAL_BITS;
    localparam int ACCW = MW + LW;
    localparam int RW   = ACCW - TW_FRAC;
    localparam int AMW  = (RW > MAG_BITS + 1) ? RW : MAG_BITS + 1;
    localparam int CLW  = (LW > LEN_BITS) ? LW : LEN_BITS;
    localparam int SQW  = 2 * MAG_BITS;

    typedef enum logic [8:0] {
        S_INIT = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_WIN  = 9'b000000100,
        S_BIN  = 9'b000001000,
        S_FIN0 = 9'b000010000,
        S_FIN1 = 9'b000100000,
        S_FIN2 = 9'b001000000,
        S_READ = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state;

    // configuration
    logic [LEN_BITS-1:0]  r_win_len;
    logic [LEN_BITS-1:0]  r_hop_len;
    logic [STEP_BITS-1:0] r_angle_step;

    // framing state
    logic [AW-1:0]         r_wp;
    logic [LW-1:0]         r_fill;
    logic [LEN_BITS-1:0]   r_since;
    logic [FRAME_BITS-1:0] r_frames;
    logic [POWER_BITS-1:0] r_min;
    logic [POWER_BITS-1:0] r_max;
    logic [BW-1:0]         r_latest_bins;
    logic                  r_have_frame;

    // frame computation
    logic [LW-1:0]          r_nlen;
    logic [BW-1:0]          r_bins;
    logic [LW-1:0]          r_n;
    logic [AW-1:0]          r_ra;
    logic [AW-1:0]          r_wn1;
    logic [AW-1:0]          r_wn2;
    logic                   r_v1;
    logic                   r_v2;
    logic signed [PW-1:0]   r_prod;
    logic signed [MW-1:0]   r_mc;
    logic signed [MW-1:0]   r_ms;
    logic signed [ACCW-1:0] r_acc_re;
    logic signed [ACCW-1:0] r_acc_im;
    logic [BW-1:0]          r_k;
    logic [STEP_BITS-1:0]   r_delta;
    logic [STEP_BITS-1:0]   r_p;
    logic [MAG_BITS-1:0]    r_ar;
    logic [MAG_BITS-1:0]    r_ai;
    logic                   r_sat;
    logic [SQW-1:0]         r_sq_r;
    logic [SQW-1:0]         r_sq_i;

    // pending result and output register
    logic                   r_res_done;
    logic [POWER_BITS-1:0]  r_res_power;
    logic [STATUS_BITS-1:0] r_res_status;
    logic                   r_out_valid;
    logic                   r_out_done;
    logic [FRAME_BITS-1:0]  r_out_frame;
    logic [POWER_BITS-1:0]  r_out_power;
    logic [POWER_BITS-1:0]  r_out_min;
    logic [POWER_BITS-1:0]  r_out_max;
    logic [STATUS_BITS-1:0] r_out_status;

    // next values at a push
    logic [AW-1:0]       n_wp;
    logic [LW-1:0]       n_fill;
    logic [LEN_BITS-1:0] n_since;
    logic                fire;

    logic                  in_acc;
    logic                  out_load;
    logic [31:0]           slot32;
    logic [31:0]           val32;
    logic [CLW-1:0]        len_wide;
    logic [LW-1:0]         eff_len;
    logic [LEN_BITS-1:0]   hop_eff;
    logic [31:0]           half32;
    logic [BW-1:0]         eff_bins;
    logic [LW:0]           wpn_w;
    logic [LW:0]           start_w;
    logic                  load_ok;
    logic                  read_ok;

    logic [SAMPLE_BITS-1:0]        ring_rd;
    logic [COEF_BITS-1:0]          win_rd;
    logic [XW-1:0]                 frame_rd;
    logic [TW_VAL_BITS-1:0]        cos_rd;
    logic [TW_VAL_BITS-1:0]        sin_rd;
    logic [POWER_BITS-1:0]         bin_rd;
    logic signed [SAMPLE_BITS-1:0] ring_s;
    logic signed [COEF_BITS-1:0]   win_s;
    logic signed [XW-1:0]          xw_s;
    logic signed [TW_VAL_BITS-1:0] cos_s;
    logic signed [TW_VAL_BITS-1:0] sin_s;
    logic signed [PW-1:0]          prod_sh;
    logic [TW_BITS-1:0]            tw_idx;
    logic [BIW-1:0]                bin_raddr;

    logic signed [ACCW-1:0] re_sh;
    logic signed [ACCW-1:0] im_sh;
    logic [RW-1:0]          re_t;
    logic [RW-1:0]          im_t;
    logic [AMW-1:0]         ar_ext;
    logic [AMW-1:0]         ai_ext;
    logic [SQW:0]           pw_sum;
    logic [POWER_BITS-1:0]  pw;
    logic                   last_bin;

    t_tw_wr tw_wr;
    logic   tw_done;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign slot32     = 32'(i_slot);
    assign val32      = 32'(unsigned'(i_value));

    // effective frame length, hop and bin count
    always_comb begin
        len_wide = CLW'(r_win_len);
        if (len_wide < CLW'(2)) begin
            eff_len = LW'(2);
        end else if (len_wide > CLW'(MAX_WINDOW)) begin
            eff_len = LW'(MAX_WINDOW);
        end else begin
            eff_len = len_wide[LW-1:0];
        end
        hop_eff  = (r_hop_len == '0) ? LEN_BITS'(1) : r_hop_len;
        half32   = 32'(eff_len >> 1);
        eff_bins = (half32 > 32'(MAX_BINS)) ? BW'(MAX_BINS) : half32[BW-1:0];
    end

    // ring pointer, fill and hop bookkeeping for a push
    always_comb begin
        n_wp = (r_wp == AW'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
        if (r_fill < eff_len) begin
            n_fill  = r_fill + 1'b1;
            n_since = r_since;
            fire    = (n_fill == eff_len);
        end else begin
            n_fill  = r_fill;
            n_since = r_since + 1'b1;
            fire    = (n_since >= hop_eff);
        end
        if (fire) begin
            n_since = '0;
        end
        wpn_w = (LW+1)'(n_wp);
        if (wpn_w >= (LW+1)'(eff_len)) begin
            start_w = wpn_w - (LW+1)'(eff_len);
        end else begin
            start_w = wpn_w + (LW+1)'(MAX_WINDOW) - (LW+1)'(eff_len);
        end
    end

    assign load_ok = (slot32 < 32'(MAX_WINDOW));
    assign read_ok = (slot32 < 32'(r_latest_bins));

    // memories
    wfps_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_opcode == OP_PUSH)),
        .i_waddr (r_wp),
        .i_wdata (val32[SAMPLE_BITS-1:0]),
        .i_raddr (r_ra),
        .o_rdata (ring_rd)
    );

    wfps_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_WINDOW)) u_win (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_opcode == OP_LOAD) && load_ok),
        .i_waddr (slot32[AW-1:0]),
        .i_wdata (val32[COEF_BITS-1:0]),
        .i_raddr (r_n[AW-1:0]),
        .o_rdata (win_rd)
    );

    assign prod_sh = r_prod >>> (COEF_BITS - 1);

    wfps_ram #(.WIDTH(XW), .DEPTH(MAX_WINDOW)) u_frame (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_WIN) && r_v2),
        .i_waddr (r_wn2),
        .i_wdata (prod_sh[XW-1:0]),
        .i_raddr (r_n[AW-1:0]),
        .o_rdata (frame_rd)
    );

    assign tw_idx = r_p[STEP_BITS-1 -: TW_BITS];

    wfps_ram #(.WIDTH(TW_VAL_BITS), .DEPTH(TW_SIZE)) u_cos (
        .i_clk   (i_clk),
        .i_we    (tw_wr.en),
        .i_waddr (tw_wr.addr),
        .i_wdata (tw_wr.data),
        .i_raddr (tw_idx),
        .o_rdata (cos_rd)
    );

    wfps_ram #(.WIDTH(TW_VAL_BITS), .DEPTH(TW_SIZE)) u_sin (
        .i_clk   (i_clk),
        .i_we    (tw_wr.en),
        .i_waddr (tw_wr.addr),
        .i_wdata (tw_wr.data),
        .i_raddr (tw_idx - TW_BITS'(TW_QUARTER)),
        .o_rdata (sin_rd)
    );

    assign bin_raddr = (r_state == S_IDLE) ? slot32[BIW-1:0] : r_k[BIW-1:0];

    wfps_ram #(.WIDTH(POWER_BITS), .DEPTH(MAX_BINS)) u_bins (
        .i_clk   (i_clk),
        .i_we    (r_state == S_FIN2),
        .i_waddr (r_k[BIW-1:0]),
        .i_wdata (pw),
        .i_raddr (bin_raddr),
        .o_rdata (bin_rd)
    );

    wfps_cos_gen u_cos_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_tw_wr (tw_wr),
        .o_done  (tw_done)
    );

    assign ring_s = ring_rd;
    assign win_s  = win_rd;
    assign xw_s   = frame_rd;
    assign cos_s  = cos_rd;
    assign sin_s  = sin_rd;

    // bin magnitude: floor shift, absolute value, saturation check
    always_comb begin
        re_sh  = r_acc_re >>> TW_FRAC;
        im_sh  = r_acc_im >>> TW_FRAC;
        re_t   = re_sh[RW-1:0];
        im_t   = im_sh[RW-1:0];
        ar_ext = AMW'(re_t[RW-1] ? (~re_t + 1'b1) : re_t);
        ai_ext = AMW'(im_t[RW-1] ? (~im_t + 1'b1) : im_t);
        pw_sum = (SQW+1)'(r_sq_r) + (SQW+1)'(r_sq_i);
        if (r_sat || (pw_sum > (SQW+1)'(PMASK))) begin
            pw = PMASK;
        end else begin
            pw = pw_sum[POWER_BITS-1:0];
        end
        last_bin = ((r_k + 1'b1) == r_bins);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len    <= WIN_LEN_RST;
            r_hop_len    <= HOP_LEN_RST;
            r_angle_step <= ANGLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIN_LEN: r_win_len    <= i_cfg_data[LEN_BITS-1:0];
                CFG_HOP_LEN: r_hop_len    <= i_cfg_data[LEN_BITS-1:0];
                CFG_ANGLE:   r_angle_step <= i_cfg_data[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_prod <= ring_s * win_s;
        r_mc   <= xw_s * cos_s;
        r_ms   <= xw_s * sin_s;
        r_wn2  <= r_wn1;
        r_sq_r <= r_ar * r_ar;
        r_sq_i <= r_ai * r_ai;
        if (r_state == S_FIN0) begin
            r_sat <= (ar_ext > AMW'(MAG_LIMIT)) || (ai_ext > AMW'(MAG_LIMIT));
            r_ar  <= ar_ext[MAG_BITS-1:0];
            r_ai  <= ai_ext[MAG_BITS-1:0];
        end
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_wp          <= '0;
            r_fill        <= '0;
            r_since       <= '0;
            r_frames      <= '0;
            r_min         <= PMASK;
            r_max         <= '0;
            r_latest_bins <= '0;
            r_have_frame  <= 1'b0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // output register: load a new word or hand the waiting one over
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    if (tw_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_res_done   <= 1'b0;
                        r_res_power  <= '0;
                        r_res_status <= ST_OK;
                        r_state      <= S_OUT;
                        case (i_opcode)
                            OP_LOAD: begin
                                r_res_status <= load_ok ? ST_OK : ST_RANGE;
                            end
                            OP_PUSH: begin
                                r_wp    <= n_wp;
                                r_fill  <= n_fill;
                                r_since <= n_since;
                                if (fire) begin
                                    r_nlen  <= eff_len;
                                    r_bins  <= eff_bins;
                                    r_ra    <= start_w[AW-1:0];
                                    r_n     <= '0;
                                    r_v1    <= 1'b0;
                                    r_v2    <= 1'b0;
                                    r_state <= S_WIN;
                                end
                            end
                            OP_READ: begin
                                if (!r_have_frame) begin
                                    r_res_status <= ST_NOFRAME;
                                end else if (!read_ok) begin
                                    r_res_status <= ST_RANGE;
                                end
                                r_state <= S_READ;
                            end
                            default: begin
                                r_res_status <= ST_RANGE;
                            end
                        endcase
                    end
                end
                S_WIN: begin
                    // ring and window read, product, shifted write
                    r_v2 <= r_v1;
                    if (r_n < r_nlen) begin
                        r_v1  <= 1'b1;
                        r_wn1 <= r_n[AW-1:0];
                        r_n   <= r_n + 1'b1;
                        r_ra  <= (r_ra == AW'(MAX_WINDOW - 1)) ? '0 : r_ra + 1'b1;
                    end else begin
                        r_v1 <= 1'b0;
                        if (!r_v1 && !r_v2) begin
                            r_k      <= '0;
                            r_delta  <= '0;
                            r_p      <= '0;
                            r_n      <= '0;
                            r_acc_re <= '0;
                            r_acc_im <= '0;
                            r_state  <= S_BIN;
                        end
                    end
                end
                S_BIN: begin
                    // one complex multiply-accumulate per cycle
                    r_v2 <= r_v1;
                    if (r_v2) begin
                        r_acc_re <= r_acc_re + ACCW'(r_mc);
                        r_acc_im <= r_acc_im - ACCW'(r_ms);
                    end
                    if (r_n < r_nlen) begin
                        r_v1 <= 1'b1;
                        r_n  <= r_n + 1'b1;
                        r_p  <= r_p + r_delta;
                    end else begin
                        r_v1 <= 1'b0;
                        if (!r_v1 && !r_v2) begin
                            r_state <= S_FIN0;
                        end
                    end
                end
                S_FIN0: begin
                    r_state <= S_FIN1;
                end
                S_FIN1: begin
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    // store bin, track extremes, move to next bin
                    if (pw > r_max) begin
                        r_max <= pw;
                    end
                    if (pw < r_min) begin
                        r_min <= pw;
                    end
                    r_k      <= r_k + 1'b1;
                    r_delta  <= r_delta + r_angle_step;
                    r_p      <= '0;
                    r_n      <= '0;
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                    if (last_bin) begin
                        r_latest_bins <= r_bins;
                        r_have_frame  <= 1'b1;
                        r_frames      <= r_frames + 1'b1;
                        r_res_done    <= 1'b1;
                        r_state       <= S_OUT;
                    end else begin
                        r_state <= S_BIN;
                    end
                end
                S_READ: begin
                    if (r_res_status == ST_OK) begin
                        r_res_power <= bin_rd;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_done   <= r_res_done;
                        r_out_frame  <= r_frames;
                        r_out_power  <= r_res_power;
                        r_out_min    <= r_min;
                        r_out_max    <= r_max;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_done     = r_out_done;
    assign o_frame_number   = r_out_frame;
    assign o_bin_power      = r_out_power;
    assign o_least_power    = r_out_min;
    assign o_greatest_power = r_out_max;
    assign o_status         = r_out_status;

endmodule
`default_nettype wire

// ----- rtl/core/wfps_ram.sv -----
`default_nettype none
module wfps_ram #(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 2048,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/wfps_cos_gen.sv -----
`default_nettype none
module wfps_cos_gen (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    output wfps_pkg::t_tw_wr     o_tw_wr,
    output logic                 o_done
);
    import wfps_pkg::*;

    typedef enum logic [3:0] {
        CG_LOAD  = 4'b0001,
        CG_ROT   = 4'b0010,
        CG_WRITE = 4'b0100,
        CG_DONE  = 4'b1000
    } t_cg_state;

    t_cg_state                     r_state;
    logic [TW_BITS-1:0]            r_idx;
    logic [3:0]                    r_stage;
    logic signed [CORDIC_BITS-1:0] r_x;
    logic signed [CORDIC_BITS-1:0] r_y;
    logic signed [CORDIC_BITS-1:0] r_z;
    logic                          r_flip;

    logic [31:0]                   phase;
    logic [31:0]                   phase_adj;
    logic                          flip;
    logic signed [CORDIC_BITS-1:0] sx;
    logic signed [CORDIC_BITS-1:0] sy;
    logic signed [CORDIC_BITS-1:0] xf;
    logic signed [CORDIC_BITS-1:0] xr;
    logic signed [TW_VAL_BITS-1:0] cos_val;

    // fold the left half plane onto the right one
    always_comb begin
        phase = {r_idx, {(32-TW_BITS){1'b0}}};
        flip  = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
        phase_adj = flip ? (phase + 32'h8000_0000) : phase;
    end

    assign sx = r_x >>> r_stage;
    assign sy = r_y >>> r_stage;

    // round to Q1.15 and clamp
    always_comb begin
        xf = r_flip ? -r_x : r_x;
        xr = (xf + CORDIC_BITS'(16384)) >>> TW_FRAC;
        if (xr > CORDIC_BITS'(32767)) begin
            cos_val = 16'sd32767;
        end else if (xr < -CORDIC_BITS'(32767)) begin
            cos_val = -16'sd32767;
        end else begin
            cos_val = xr[TW_VAL_BITS-1:0];
        end
    end

    assign o_tw_wr = '{en: (r_state == CG_WRITE), addr: r_idx, data: cos_val};
    assign o_done  = (r_state == CG_DONE);

    // one table entry per rotation sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CG_LOAD;
            r_idx   <= '0;
            r_stage <= '0;
        end else begin
            unique case (r_state)
                CG_LOAD: begin
                    r_x     <= CORDIC_X0;
                    r_y     <= '0;
                    r_z     <= {{(CORDIC_BITS-32){phase_adj[31]}}, phase_adj};
                    r_flip  <= flip;
                    r_stage <= '0;
                    r_state <= CG_ROT;
                end
                CG_ROT: begin
                    if (!r_z[CORDIC_BITS-1]) begin
                        r_x <= r_x - sy;
                        r_y <= r_y + sx;
                        r_z <= r_z - atan_unit(r_stage);
                    end else begin
                        r_x <= r_x + sy;
                        r_y <= r_y - sx;
                        r_z <= r_z + atan_unit(r_stage);
                    end
                    if (r_stage == 4'(CORDIC_STAGES - 1)) begin
                        r_state <= CG_WRITE;
                    end else begin
                        r_stage <= r_stage + 4'd1;
                    end
                end
                CG_WRITE: begin
                    if (r_idx == TW_BITS'(TW_SIZE - 1)) begin
                        r_state <= CG_DONE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= CG_LOAD;
                    end
                end
                CG_DONE: begin
                    r_state <= CG_DONE;
                end
                default: begin
                    r_state <= CG_LOAD;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/wfps_checker.sv -----
`default_nettype none
module wfps_checker (
    input wire logic                                   i_clk,
    input wire logic                                   i_rst_n,
    input wire logic                                   o_out_valid,
    input wire logic                                   i_out_ready,
    input wire logic                                   o_frame_done,
    input wire logic [wfps_pkg::FRAME_BITS-1:0]        o_frame_number,
    input wire logic [wfps_pkg::POWER_BITS-1:0]        o_bin_power,
    input wire logic [wfps_pkg::POWER_BITS-1:0]        o_least_power,
    input wire logic [wfps_pkg::POWER_BITS-1:0]        o_greatest_power,
    input wire logic [wfps_pkg::STATUS_BITS-1:0]       o_status
);
    import wfps_pkg::*;

    // no result word right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

    // a waiting result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_bin_power)
            && $stable(o_status) && $stable(o_frame_number))
        else $error("stalled result word changed");

    // a completed frame is always reported as ok
    a_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_status == ST_OK)
        else $error("frame done with error status");

    // errors carry no power
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_bin_power == '0)
        else $error("error word carries power");

    // once a frame exists the minimum does not exceed the maximum
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_number != '0 |-> o_least_power <= o_greatest_power)
        else $error("running minimum above maximum");

endmodule

bind windowed_frame_power_spectrum_unit wfps_checker u_wfps_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_frame_done     (o_frame_done),
    .o_frame_number   (o_frame_number),
    .o_bin_power      (o_bin_power),
    .o_least_power    (o_least_power),
    .o_greatest_power (o_greatest_power),
    .o_status         (o_status)
);
`default_nettype wire
